@@ rtl/core/apd_pkg.sv @@
`timescale 1ns / 1ps

package apd_pkg;

  // Default limits of the line store and the row counter.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Width of the size registers on the configuration port.
  localparam int CFG_W = 11;

  // Pixel width of the plane.
  localparam int PIX_W = 8;

  // Depth of the result queue in front of the output port.
  localparam int OUT_FIFO_DEPTH = 4;

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // One decoded pixel with its position flags.
  typedef struct packed {
    logic [PIX_W-1:0] alpha_value;
    logic             row_end;
    logic             image_end;
  } apd_result_t;

endpackage

@@ rtl/core/alpha_plane_predictor_decode_top.sv @@
`timescale 1ns / 1ps

// Order: a residual word is registered into stage 1 with its line store read, where the
// pixel is built and pushed into the result queue; a pad word gives no output word.
// Throughput: one input word per cycle while the result queue has room, set by one line
// store read and one write per pixel. Reset: position counters, the pad flag and the left
// pixel clear, both size registers return to 1; the line store keeps whatever it held.
module alpha_plane_predictor_decode_top #(
  parameter int MAX_WIDTH  = apd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = apd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write channel.
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_addr_i,
  input  logic [apd_pkg::CFG_W-1:0] cfg_data_i,
  // Residual stream in.
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] residual_byte
  // Pixel stream out.
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // [7:0] alpha_value
  output logic                      m_axis_tlast,  // row_end
  output logic                      m_axis_tuser   // [0] image_end
);

  import apd_pkg::*;

  // Widths: AW indexes the line store, WW holds a width up to MAX_WIDTH,
  // HW holds a height up to MAX_HEIGHT. Size registers are compared at a
  // width wide enough for both the register and the limit.
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CWW = (WW > CFG_W) ? WW : CFG_W;
  localparam int CHW = (HW > CFG_W) ? HW : CFG_W;
  localparam int FCW = $clog2(OUT_FIFO_DEPTH + 1);

  // Configuration registers.
  logic [CFG_W-1:0] width_q, height_q;

  // Position state, updated as each word is accepted.
  logic [AW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic          pad_q, pad_d;

  // Stage 1: the line store answer arrives here and the pixel is built.
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_res_q;
  logic [AW-1:0]    s1_addr_q;
  logic             s1_row0_q;
  logic             s1_col0_q;
  logic             s1_rend_q;
  logic             s1_iend_q;
  logic             s1_fwd_q;

  logic [PIX_W-1:0] left_q, left_d;

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [AW-1:0]    col_cur;
  logic             in_fire;
  logic             launch;
  logic             rend;
  logic             iend;
  logic [PIX_W-1:0] above;
  logic [PIX_W-1:0] base;
  logic [PIX_W-1:0] pix;
  logic [PIX_W-1:0] ram_rdata;

  apd_result_t      push_data;
  apd_result_t      out_data;
  logic [FCW-1:0]   fifo_count;

  // The port never stalls; the user writes the registers only while idle, unchecked.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == REG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
    end
  end

  // Effective sizes: zero counts as one, anything above the limit saturates.
  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (CWW'(width_q) > CWW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (CHW'(height_q) > CHW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  // The input side is open only while the result queue, counting the pixel in stage 1,
  // has room for the new word with one entry to spare, so the queue never overflows.
  assign s_axis_tready = (fifo_count + FCW'(s1_valid_q)) <= FCW'(OUT_FIFO_DEPTH - 2);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign launch        = in_fire && !pad_q;

  // A column left past the end by a smaller width is pulled back to the last column.
  assign col_cur = (WW'(col_q) >= w_eff) ? AW'(w_eff - 1'b1) : col_q;
  assign rend    = (WW'(col_cur) + 1'b1) >= w_eff;
  assign iend    = rend && ((row_q + 1'b1) >= h_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    pad_d = pad_q;
    if (in_fire) begin
      if (pad_q) begin
        pad_d = 1'b0;
      end else if (rend) begin
        col_d = '0;
        pad_d = w_eff[0];
        row_d = iend ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      pad_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      left_q     <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      pad_q      <= pad_d;
      s1_valid_q <= launch;
      left_q     <= left_d;
    end
  end

  // The previous pixel is written back in the same cycle as this read. When it
  // is the same entry the store answers stale data, so the fresh value is taken
  // from the left pixel register instead.
  always_ff @(posedge clk_i) begin
    if (launch) begin
      s1_res_q  <= s_axis_tdata;
      s1_addr_q <= col_cur;
      s1_row0_q <= (row_q == '0);
      s1_col0_q <= (col_cur == '0);
      s1_rend_q <= rend;
      s1_iend_q <= iend;
      s1_fwd_q  <= s1_valid_q && (s1_addr_q == col_cur);
    end
  end

  apd_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_addr_q),
    .wdata_i(pix),
    .re_i   (launch),
    .raddr_i(col_cur),
    .rdata_o(ram_rdata)
  );

  // Prediction: first pixel as is, rest of row 0 from the left, column 0 of
  // later rows from above, and the floor of the average everywhere else.
  assign above = s1_fwd_q ? left_q : ram_rdata;

  always_comb begin
    if (s1_row0_q) begin
      base = s1_col0_q ? '0 : left_q;
    end else if (s1_col0_q) begin
      base = above;
    end else begin
      base = PIX_W'(((PIX_W + 1)'(left_q) + (PIX_W + 1)'(above)) >> 1);
    end
  end

  always_comb begin
    if (s1_row0_q && s1_col0_q) begin
      pix = s1_res_q;
    end else begin
      pix = base - s1_res_q;
    end
  end

  assign left_d = s1_valid_q ? pix : left_q;

  assign push_data.alpha_value = pix;
  assign push_data.row_end     = s1_rend_q;
  assign push_data.image_end   = s1_iend_q;

  apd_out_fifo #(
    .DEPTH(OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s1_valid_q),
    .push_data_i(push_data),
    .pop_i      (m_axis_tready),
    .valid_o    (m_axis_tvalid),
    .data_o     (out_data),
    .count_o    (fifo_count)
  );

  assign m_axis_tdata = out_data.alpha_value;
  assign m_axis_tlast = out_data.row_end;
  assign m_axis_tuser = out_data.image_end;

endmodule

@@ rtl/core/apd_ram.sv @@
`timescale 1ns / 1ps

module apd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/apd_out_fifo.sv @@
`timescale 1ns / 1ps

module apd_out_fifo #(
  parameter int DEPTH = apd_pkg::OUT_FIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  apd_pkg::apd_result_t       push_data_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output apd_pkg::apd_result_t       data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  import apd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  apd_result_t   entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
